// ===== rtl/ptrust_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrust_pkg
// shared constants, register indexes and helpers of the parent trust table
// ----------------------------------------------------------------------------
`default_nettype none

package ptrust_pkg;

   localparam int NUM_PARENTS_DEF      = 16;
   localparam int MIN_HOP_RANK_INC_DEF = 256;

   localparam int TRUST_W   = 10;
   localparam int RANK_W    = 16;
   localparam int TIME_W    = 32;
   localparam int INDEX_W   = 4;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   localparam logic [TRUST_W-1:0] FULL_TRUST = 10'd1000;
   localparam logic [TRUST_W-1:0] FLOOR_DEF  = 10'd300;

   // divider widths
   localparam int DIVQ_W = 32;
   localparam int DIVD_W = 23;
   localparam int DCNT_W = 5;

   localparam logic [DIVQ_W-1:0] SCALE_SQ = 32'd1000000;

   // x / 1000 as (x * RECIP_1000) >> RECIP_SH, exact for 32-bit x
   localparam int                 RECIP_W    = 29;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
   localparam int                 RECIP_SH   = 38;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BETA       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAU        = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KAPPA      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ADV_LAMBDA = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STB_LAMBDA = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR      = 4'd7;

   // commands
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_INIT   = 1'b1;

   // sequencer steps
   typedef enum logic [3:0] {
      STEP_PEN_A  = 4'd0,
      STEP_ADV_S  = 4'd1,
      STEP_PEN_S  = 4'd2,
      STEP_STB_S  = 4'd3,
      STEP_ADV_N  = 4'd4,
      STEP_STB_N  = 4'd5,
      STEP_GRAY_N = 4'd6,
      STEP_SINK   = 4'd7,
      STEP_TOTAL  = 4'd8
   } step_type;

   function automatic logic [TRUST_W-1:0] sat_scale(input logic [TRUST_W-1:0] v);
      sat_scale = (v > FULL_TRUST) ? FULL_TRUST : v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/parent_trust_ewma_update.sv =====
// ----------------------------------------------------------------------------
// parent_trust_ewma_update
// per-parent trust table with smoothed advertisement, stability and gray trust
// ----------------------------------------------------------------------------
// A command beat is taken on start while busy is low. An init command writes
// full trust into the entry and returns total and sink trust of 1000 on the
// next cycle; an index beyond the table returns zeros on the next cycle and
// leaves the table alone. Both can follow each other every cycle. An update
// reads the entry from the table memory, then runs nine steps: seven divisions
// by 1000 through a reciprocal multiply (each a setup state, then the multiply)
// and two trust divisions through a restoring divider of one quotient
// bit per cycle (each a setup state, then the divider run). The read state,
// the steps and the write-back state come before the result beat; busy stays
// high until the result beat, so a new command is not taken before an update
// is done. The result beat is on rsp_valid for one cycle and the receiver
// cannot stall it.
// Reset sets the registers to their defaults and marks every entry invalid;
// an invalid entry reads as full trust, so no clearing pass is needed.
// Register writes are taken at any edge with csr_write_enable high.
// ----------------------------------------------------------------------------
`default_nettype none

module parent_trust_ewma_update #(
   parameter int NUM_PARENTS      = ptrust_pkg::NUM_PARENTS_DEF,
   parameter int MIN_HOP_RANK_INC = ptrust_pkg::MIN_HOP_RANK_INC_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire                                   req_command,
   input  wire  [ptrust_pkg::INDEX_W-1:0]        req_parent_index,
   input  wire  [ptrust_pkg::RANK_W-1:0]         req_parent_rank,
   input  wire  [ptrust_pkg::RANK_W-1:0]         req_own_rank,
   input  wire  [ptrust_pkg::RANK_W-1:0]         req_last_rank,
   input  wire  [ptrust_pkg::TIME_W-1:0]         req_now_seconds,
   input  wire  [ptrust_pkg::TIME_W-1:0]         req_last_update_seconds,
   input  wire  [ptrust_pkg::TRUST_W-1:0]        req_gray_trust,
   output logic                                  rsp_valid,
   output logic [ptrust_pkg::TRUST_W-1:0]        rsp_total_trust,
   output logic [ptrust_pkg::TRUST_W-1:0]        rsp_sink_trust,
   input  wire                                   csr_write_enable,
   input  wire  [ptrust_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [ptrust_pkg::CSR_DAT_W-1:0]      csr_write_data
);

   localparam int AW    = (NUM_PARENTS > 1) ? $clog2(NUM_PARENTS) : 1;
   localparam int TW    = ptrust_pkg::TRUST_W;
   localparam int RW    = ptrust_pkg::RANK_W;
   localparam int QW    = ptrust_pkg::DIVQ_W;
   localparam int DW    = ptrust_pkg::DIVD_W;
   localparam int CW    = ptrust_pkg::DCNT_W;
   localparam int PW    = QW + ptrust_pkg::RECIP_W;
   localparam int MEM_W = 3 * TW;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_SETUP = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_WB    = 5'b10000
   } state_type;

   // configuration
   logic [TW-1:0] beta_ff, alpha_ff, floor_ff;
   logic [RW-1:0] tau_ff, kappa_ff, adv_lambda_ff, stb_lambda_ff, window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff       <= 10'd500;
         alpha_ff      <= 10'd500;
         tau_ff        <= '0;
         kappa_ff      <= '0;
         adv_lambda_ff <= 16'd1000;
         stb_lambda_ff <= 16'd1000;
         window_ff     <= '0;
         floor_ff      <= ptrust_pkg::FLOOR_DEF;
      end else if (csr_write_enable) begin
         case (csr_index)
            ptrust_pkg::CSR_BETA:       beta_ff       <= csr_write_data[TW-1:0];
            ptrust_pkg::CSR_ALPHA:      alpha_ff      <= csr_write_data[TW-1:0];
            ptrust_pkg::CSR_TAU:        tau_ff        <= csr_write_data;
            ptrust_pkg::CSR_KAPPA:      kappa_ff      <= csr_write_data;
            ptrust_pkg::CSR_ADV_LAMBDA: adv_lambda_ff <= csr_write_data;
            ptrust_pkg::CSR_STB_LAMBDA: stb_lambda_ff <= csr_write_data;
            ptrust_pkg::CSR_WINDOW:     window_ff     <= csr_write_data;
            ptrust_pkg::CSR_FLOOR:      floor_ff      <= csr_write_data[TW-1:0];
            default: ;
         endcase
      end
   end

   logic [TW-1:0] beta, alpha, floor_v;
   assign beta    = ptrust_pkg::sat_scale(beta_ff);
   assign alpha   = ptrust_pkg::sat_scale(alpha_ff);
   assign floor_v = ptrust_pkg::sat_scale(floor_ff);

   // control
   state_type           state_ff, state_in;
   ptrust_pkg::step_type step_ff;
   logic [CW-1:0]       cnt_ff;
   logic                accept, in_range;

   assign accept   = start && !busy;
   assign in_range = ({1'b0, 9'(req_parent_index)} < 10'(NUM_PARENTS));
   assign busy     = (state_ff != ST_IDLE);

   // latched command
   logic [AW-1:0] addr_ff;
   logic [RW-1:0] prank_ff, orank_ff, lrank_ff;
   logic [31:0]   now_ff, last_ff;
   logic [TW-1:0] gray_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff  <= AW'(req_parent_index);
         prank_ff <= req_parent_rank;
         orank_ff <= req_own_rank;
         lrank_ff <= req_last_rank;
         now_ff   <= req_now_seconds;
         last_ff  <= req_last_update_seconds;
         gray_ff  <= ptrust_pkg::sat_scale(req_gray_trust);
      end
   end

   // table memory {advert, stability, gray} with per-entry valid
   logic [MEM_W-1:0]       mem [NUM_PARENTS];
   logic [NUM_PARENTS-1:0] valid_ff;
   logic [MEM_W-1:0]       rd_ff;
   logic                   rd_valid_ff;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [MEM_W-1:0]       wr_data;

   logic [TW-1:0] adv_n_ff, stb_n_ff, gray_n_ff;
   logic          init_wr;

   assign init_wr = accept && in_range && (req_command == ptrust_pkg::CMD_INIT);
   assign wr_en   = init_wr || (state_ff == ST_WB);
   assign wr_addr = init_wr ? AW'(req_parent_index) : addr_ff;
   assign wr_data = init_wr ? {3{ptrust_pkg::FULL_TRUST}} : {adv_n_ff, stb_n_ff, gray_n_ff};

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (state_ff == ST_READ)
         rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ)
         rd_valid_ff <= valid_ff[addr_ff];
   end

   logic [TW-1:0] old_a, old_s, old_g;
   assign old_a = rd_valid_ff ? rd_ff[3*TW-1:2*TW] : ptrust_pkg::FULL_TRUST;
   assign old_s = rd_valid_ff ? rd_ff[2*TW-1:TW]   : ptrust_pkg::FULL_TRUST;
   assign old_g = rd_valid_ff ? rd_ff[TW-1:0]      : ptrust_pkg::FULL_TRUST;

   // rank excess terms
   logic [18:0] d_a;
   logic [17:0] d_s;
   logic        hist_ok;
   logic [16:0] exc_a_ff;
   logic [15:0] exc_s_ff;

   assign d_a = {3'b0, orank_ff} - {3'b0, prank_ff} - 19'(MIN_HOP_RANK_INC) - {3'b0, tau_ff};
   assign d_s = {2'b0, orank_ff} - {2'b0, lrank_ff} - {2'b0, kappa_ff};
   assign hist_ok = (last_ff != '0) && ((now_ff - last_ff) >= {16'b0, window_ff});

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         exc_a_ff <= (!d_a[18] && d_a != '0) ? d_a[16:0] : '0;
         exc_s_ff <= (hist_ok && !d_s[17] && d_s != '0) ? d_s[15:0] : '0;
      end
   end

   // step operands
   logic [DW-1:0] pen_a_ff, pen_s_ff;
   logic [TW-1:0] adv_s_ff, stb_s_ff, sink_ff, total_ff;
   logic [QW-1:0] num_sel;
   logic [DW-1:0] den_sel;
   logic [32:0]   prod_p;

   always_comb begin
      prod_p  = '0;
      num_sel = '0;
      den_sel = DW'(ptrust_pkg::FULL_TRUST);
      case (step_ff)
         ptrust_pkg::STEP_PEN_A: begin
            prod_p  = {16'b0, exc_a_ff} * {17'b0, adv_lambda_ff};
            num_sel = prod_p[31:0];
         end
         ptrust_pkg::STEP_ADV_S: begin
            num_sel = ptrust_pkg::SCALE_SQ;
            den_sel = DW'(ptrust_pkg::FULL_TRUST) + pen_a_ff;
         end
         ptrust_pkg::STEP_PEN_S: begin
            prod_p  = {17'b0, exc_s_ff} * {17'b0, stb_lambda_ff};
            num_sel = prod_p[31:0];
         end
         ptrust_pkg::STEP_STB_S: begin
            num_sel = ptrust_pkg::SCALE_SQ;
            den_sel = DW'(ptrust_pkg::FULL_TRUST) + pen_s_ff;
         end
         ptrust_pkg::STEP_ADV_N:
            num_sel = QW'(ptrust_pkg::FULL_TRUST - beta) * QW'(old_a)
                    + QW'(beta) * QW'(adv_s_ff);
         ptrust_pkg::STEP_STB_N:
            num_sel = QW'(ptrust_pkg::FULL_TRUST - beta) * QW'(old_s)
                    + QW'(beta) * QW'(stb_s_ff);
         ptrust_pkg::STEP_GRAY_N:
            num_sel = QW'(ptrust_pkg::FULL_TRUST - beta) * QW'(old_g)
                    + QW'(beta) * QW'(gray_ff);
         ptrust_pkg::STEP_SINK:
            num_sel = QW'(adv_n_ff) * QW'(stb_n_ff);
         ptrust_pkg::STEP_TOTAL:
            num_sel = QW'(alpha) * QW'(gray_n_ff)
                    + QW'(ptrust_pkg::FULL_TRUST - alpha) * QW'(sink_ff);
         default: ;
      endcase
   end

   // restoring divider, one quotient bit per cycle
   logic [QW-1:0] q_ff;
   logic [DW-1:0] rem_ff, den_ff;
   logic [DW:0]   shifted;
   logic          fits;

   assign shifted = {rem_ff, q_ff[QW-1]};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (state_ff == ST_SETUP) begin
         q_ff   <= num_sel;
         den_ff <= den_sel;
         rem_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         q_ff   <= {q_ff[QW-2:0], fits};
         rem_ff <= fits ? DW'(shifted - {1'b0, den_ff}) : shifted[DW-1:0];
      end
   end

   // division by 1000 through the reciprocal multiply
   logic          var_step;
   logic [PW-1:0] recip_prod;

   assign var_step   = step_ff inside {ptrust_pkg::STEP_ADV_S, ptrust_pkg::STEP_STB_S};
   assign recip_prod = PW'(q_ff) * PW'(ptrust_pkg::RECIP_1000);

   logic          div_last;
   logic [QW-1:0] quot;
   logic [TW-1:0] total_fl;

   assign div_last = (state_ff == ST_DIV) && (!var_step || cnt_ff == CW'(QW - 1));
   assign quot     = var_step ? {q_ff[QW-2:0], fits}
                              : QW'(recip_prod[PW-1:ptrust_pkg::RECIP_SH]);
   assign total_fl = (quot[TW-1:0] < floor_v) ? floor_v : quot[TW-1:0];

   always_ff @(posedge clock) begin
      if (div_last) begin
         case (step_ff)
            ptrust_pkg::STEP_PEN_A:  pen_a_ff  <= quot[DW-1:0];
            ptrust_pkg::STEP_ADV_S:  adv_s_ff  <= quot[TW-1:0];
            ptrust_pkg::STEP_PEN_S:  pen_s_ff  <= quot[DW-1:0];
            ptrust_pkg::STEP_STB_S:  stb_s_ff  <= quot[TW-1:0];
            ptrust_pkg::STEP_ADV_N:  adv_n_ff  <= quot[TW-1:0];
            ptrust_pkg::STEP_STB_N:  stb_n_ff  <= quot[TW-1:0];
            ptrust_pkg::STEP_GRAY_N: gray_n_ff <= quot[TW-1:0];
            ptrust_pkg::STEP_SINK:   sink_ff   <= quot[TW-1:0];
            ptrust_pkg::STEP_TOTAL:  total_ff  <= total_fl;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (accept && in_range && req_command == ptrust_pkg::CMD_UPDATE)
               state_in = ST_READ;
         ST_READ:  state_in = ST_SETUP;
         ST_SETUP: state_in = ST_DIV;
         ST_DIV:
            if (div_last)
               state_in = (step_ff == ptrust_pkg::STEP_TOTAL) ? ST_WB : ST_SETUP;
         ST_WB:    state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= ptrust_pkg::STEP_PEN_A;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_READ)
            step_ff <= ptrust_pkg::STEP_PEN_A;
         else if (div_last && step_ff != ptrust_pkg::STEP_TOTAL)
            step_ff <= ptrust_pkg::step_type'(step_ff + 4'd1);
         if (state_ff == ST_DIV)
            cnt_ff <= cnt_ff + CW'(1);
         else
            cnt_ff <= '0;
      end
   end

   // result beat
   logic          rsp_valid_ff;
   logic [TW-1:0] rsp_total_ff, rsp_sink_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (accept && (!in_range || req_command == ptrust_pkg::CMD_INIT))
                      || (state_ff == ST_WB);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !in_range) begin
         rsp_total_ff <= '0;
         rsp_sink_ff  <= '0;
      end else if (init_wr) begin
         rsp_total_ff <= ptrust_pkg::FULL_TRUST;
         rsp_sink_ff  <= ptrust_pkg::FULL_TRUST;
      end else if (state_ff == ST_WB) begin
         rsp_total_ff <= total_ff;
         rsp_sink_ff  <= sink_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_trust = rsp_total_ff;
   assign rsp_sink_trust  = rsp_sink_ff;

   // checks
   a_beat_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept || state_ff == ST_WB))
      else $error("result beat without a command or write-back");

   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) |=> (rsp_valid && !busy))
      else $error("update finished without a result beat");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_range) |=> (rsp_valid && rsp_total_trust == '0 && rsp_sink_trust == '0))
      else $error("out of range command gave a nonzero result");

   a_total_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) |-> (total_ff >= floor_v && total_ff <= ptrust_pkg::FULL_TRUST))
      else $error("total trust outside floor and scale");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> (step_ff <= ptrust_pkg::STEP_TOTAL))
      else $error("sequencer step beyond the last step");

endmodule

`default_nettype wire
